@@ design/lct_pkg.sv @@
// Shared constants, codes and the entry word of the LRU key-value cache.
// Used by the channel interfaces, the entry RAM and the top level.
package lct_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int TIME_W  = 32;
  localparam int TTL_W   = 31;
  localparam int CAP_W   = 7;
  localparam int REQ_W   = 2;
  localparam int CFG_W   = 31;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_GET = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEL = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLR = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_TTL      = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One stored entry; rank 0 is the most recent.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] stamp;
    idx_t              rank;
  } entry_t;

endpackage

@@ design/lct_req_if.sv @@
// Request channel of the cache: valid/ready handshake and request word.
// Depends on lct_pkg.
interface lct_req_if;
  logic                      valid;
  logic                      ready;
  logic [lct_pkg::REQ_W-1:0] req_type;
  logic [lct_pkg::KEY_W-1:0] key;
  logic [lct_pkg::VAL_W-1:0] write_value;
  logic [lct_pkg::TIME_W-1:0] now;

  modport source (output valid, req_type, key, write_value, now, input ready);
  modport sink (input valid, req_type, key, write_value, now, output ready);
endinterface

@@ design/lct_rsp_if.sv @@
// Response channel of the cache: valid/ready handshake and result word.
// Depends on lct_pkg.
interface lct_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [lct_pkg::VAL_W-1:0] read_value;
  logic [lct_pkg::CNT_W-1:0] entries_in_use;

  modport source (output valid, hit, read_value, entries_in_use, input ready);
  modport sink (input valid, hit, read_value, entries_in_use, output ready);
endinterface

@@ design/lct_entry_ram.sv @@
// Entry store of the cache: one write port, one registered read port.
// Depends on lct_pkg.
module lct_entry_ram (
  input  logic            clk,
  input  logic            rd_en,
  input  lct_pkg::idx_t   rd_addr,
  output lct_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  lct_pkg::idx_t   wr_addr,
  input  lct_pkg::entry_t wr_data
);

  lct_pkg::entry_t mem [lct_pkg::ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/lru_cache_with_ttl.sv @@
// Top level of the LRU key-value cache with time-to-live.
// Depends on lct_pkg, lct_req_if, lct_rsp_if and lct_entry_ram.
//
//   channel | direction | word
//   req     | in        | req_type, key, write_value, now
//   rsp     | out       | hit, read_value, entries_in_use
//   cfg     | in        | cfg_we, cfg_index, cfg_wdata (capacity, ttl_seconds)
//
// A request needs one pass when no entry changes (get miss, delete of an
// absent key, put with capacity zero, clear) and a second pass when entries change:
// each pass sweeps all 64 RAM entries through the single read port.
// Reset clears the valid bits and the live count at once; no sweep follows.
// A finished word waits in the output register while the next request is taken.
module lru_cache_with_ttl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [lct_pkg::CFG_W-1:0] cfg_wdata,
  lct_req_if.sink                   req,
  lct_rsp_if.source                 rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPD    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  localparam logic [1:0] OP_PROMOTE = 2'd0;
  localparam logic [1:0] OP_DROP    = 2'd1;
  localparam logic [1:0] OP_PUT     = 2'd2;

  localparam lct_pkg::cnt_t FULL = lct_pkg::CNT_W'(lct_pkg::ENTRIES);

  logic [2:0]                  state;
  lct_pkg::cnt_t               cnt;
  logic                        p_vld;
  lct_pkg::idx_t               p_idx;
  logic [lct_pkg::ENTRIES-1:0] valid_bits;
  lct_pkg::cnt_t               live_count;
  logic [lct_pkg::CAP_W-1:0]   capacity;
  logic [lct_pkg::TTL_W-1:0]   ttl;

  logic [lct_pkg::REQ_W-1:0]  r_type;
  logic [lct_pkg::KEY_W-1:0]  r_key;
  logic [lct_pkg::VAL_W-1:0]  r_val;
  logic [lct_pkg::TIME_W-1:0] r_now;

  logic                       hm;
  lct_pkg::idx_t              m_idx;
  lct_pkg::idx_t              m_rank;
  logic [lct_pkg::VAL_W-1:0]  m_value;
  logic [lct_pkg::TIME_W-1:0] m_stamp;
  logic                       free_found;
  lct_pkg::idx_t              f_idx;
  lct_pkg::idx_t              lru_idx;

  logic [1:0]                op;
  lct_pkg::idx_t             slot;
  lct_pkg::cnt_t             keep_c;
  logic                      res_hit;
  logic [lct_pkg::VAL_W-1:0] res_value;

  logic                      o_valid;
  logic                      o_hit;
  logic [lct_pkg::VAL_W-1:0] o_value;
  lct_pkg::cnt_t             o_count;

  logic            rd_en;
  lct_pkg::entry_t rd_data;
  logic            wr_en;
  lct_pkg::entry_t wr_data;

  logic                       pass_active;
  lct_pkg::cnt_t              cap_eff;
  lct_pkg::cnt_t              n1;
  logic                       k1;
  logic                       k2;
  lct_pkg::cnt_t              after_ins;
  logic [lct_pkg::TIME_W-1:0] age;
  lct_pkg::idx_t              rank_c;
  logic                       new_valid;

  lct_entry_ram u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (cnt[lct_pkg::IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (p_idx),
    .wr_data (wr_data)
  );

  assign pass_active = (state == S_SCAN) || (state == S_UPD);
  assign rd_en       = pass_active && !cnt[lct_pkg::IDX_W];

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = o_valid;
  assign rsp.hit        = o_hit;
  assign rsp.read_value = o_value;
  assign rsp.entries_in_use = o_count;

  // Put bookkeeping: evictions needed and how many old entries survive.
  always_comb begin
    cap_eff   = (capacity > FULL) ? FULL : capacity;
    n1        = live_count - lct_pkg::CNT_W'(hm);
    k1        = (n1 == FULL);
    after_ins = n1 - lct_pkg::CNT_W'(k1) + lct_pkg::CNT_W'(1);
    k2        = (after_ins > cap_eff);
    age       = r_now - m_stamp;
  end

  // Rank update of the entry coming back from the RAM in the update pass.
  always_comb begin
    wr_data   = rd_data;
    new_valid = valid_bits[p_idx];
    rank_c    = rd_data.rank - lct_pkg::IDX_W'(hm && (rd_data.rank > m_rank));
    case (op)
      OP_PROMOTE: begin
        if (p_idx == m_idx) begin
          wr_data.rank = '0;
        end else if (rd_data.rank < m_rank) begin
          wr_data.rank = rd_data.rank + lct_pkg::IDX_W'(1);
        end
      end
      OP_DROP: begin
        if (p_idx == m_idx) begin
          new_valid = 1'b0;
        end else if (rd_data.rank > m_rank) begin
          wr_data.rank = rd_data.rank - lct_pkg::IDX_W'(1);
        end
      end
      OP_PUT: begin
        if (p_idx == slot) begin
          wr_data.key   = r_key;
          wr_data.value = r_val;
          wr_data.stamp = r_now;
          wr_data.rank  = '0;
          new_valid     = 1'b1;
        end else if (lct_pkg::CNT_W'(rank_c) < keep_c) begin
          wr_data.rank = rank_c + lct_pkg::IDX_W'(1);
        end else begin
          new_valid = 1'b0;
        end
      end
      default: begin
        wr_data = rd_data;
      end
    endcase
    wr_en = (state == S_UPD) && p_vld && (valid_bits[p_idx] || (op == OP_PUT && p_idx == slot));
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lct_pkg::CAP_W'(lct_pkg::ENTRIES);
      ttl      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == lct_pkg::CFG_CAPACITY) begin
        capacity <= cfg_wdata[lct_pkg::CAP_W-1:0];
      end else begin
        ttl <= cfg_wdata[lct_pkg::TTL_W-1:0];
      end
    end
  end

  // Request sequencer: scan pass, decision, update pass, result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      p_vld      <= 1'b0;
      valid_bits <= '0;
      live_count <= '0;
      o_valid    <= 1'b0;
    end else begin
      p_vld <= rd_en;
      p_idx <= cnt[lct_pkg::IDX_W-1:0];
      if (pass_active && !cnt[lct_pkg::IDX_W]) begin
        cnt <= cnt + lct_pkg::CNT_W'(1);
      end
      if (o_valid && rsp.ready && state != S_FIN) begin
        o_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            r_type     <= req.req_type;
            r_key      <= req.key;
            r_val      <= req.write_value;
            r_now      <= req.now;
            cnt        <= '0;
            hm         <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end

        // Look for the key, a free slot and the least recent entry.
        S_SCAN: begin
          if (p_vld) begin
            if (valid_bits[p_idx]) begin
              if (!hm && rd_data.key == r_key) begin
                hm      <= 1'b1;
                m_idx   <= p_idx;
                m_rank  <= rd_data.rank;
                m_value <= rd_data.value;
                m_stamp <= rd_data.stamp;
              end
              if (lct_pkg::CNT_W'(rd_data.rank) == live_count - lct_pkg::CNT_W'(1)) begin
                lru_idx <= p_idx;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              f_idx      <= p_idx;
            end
          end
          if (cnt[lct_pkg::IDX_W]) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          cnt       <= '0;
          res_hit   <= 1'b0;
          res_value <= '0;
          state     <= S_FIN;
          case (r_type)
            lct_pkg::REQ_GET: begin
              if (hm) begin
                state <= S_UPD;
                if (ttl != '0 && age > {1'b0, ttl}) begin
                  op         <= OP_DROP;
                  live_count <= live_count - lct_pkg::CNT_W'(1);
                end else begin
                  op        <= OP_PROMOTE;
                  res_hit   <= 1'b1;
                  res_value <= m_value;
                end
              end
            end
            lct_pkg::REQ_PUT: begin
              if (cap_eff != '0) begin
                op         <= OP_PUT;
                keep_c     <= n1 - lct_pkg::CNT_W'(k1) - lct_pkg::CNT_W'(k2);
                live_count <= n1 - lct_pkg::CNT_W'(k1) - lct_pkg::CNT_W'(k2)
                              + lct_pkg::CNT_W'(1);
                slot       <= hm ? m_idx : (free_found ? f_idx : lru_idx);
                state      <= S_UPD;
              end
            end
            lct_pkg::REQ_DEL: begin
              if (hm) begin
                op         <= OP_DROP;
                live_count <= live_count - lct_pkg::CNT_W'(1);
                state      <= S_UPD;
              end
            end
            default: begin
              valid_bits <= '0;
              live_count <= '0;
            end
          endcase
        end

        // Read every entry, modify it and write back the valid ones and the put slot.
        S_UPD: begin
          if (p_vld) begin
            valid_bits[p_idx] <= new_valid;
          end
          if (cnt[lct_pkg::IDX_W]) begin
            state <= S_FIN;
          end
        end

        // Hand the result word to the output register once it is free.
        S_FIN: begin
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_hit   <= res_hit;
            o_value <= res_value;
            o_count <= live_count;
            state   <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
